/* rtl/dbus_call_header_parser_assert.svh */
// assertion macros shared by the call header parser modules
// expects clk and arst_n in the scope of every use

`ifndef DBUS_CALL_HEADER_PARSER_ASSERT_SVH
`define DBUS_CALL_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DBCP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DBCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dbcp_pkg.sv */
// types and constants of the call header parser
// no dependencies
`default_nettype none

package dbcp_pkg;

	// header field type bytes on the wire
	localparam logic [7:0] FTYPE_DEST   = 8'd6;
	localparam logic [7:0] FTYPE_PATH   = 8'd1;
	localparam logic [7:0] FTYPE_IFACE  = 8'd2;
	localparam logic [7:0] FTYPE_METHOD = 8'd3;
	localparam logic [7:0] FTYPE_SIG    = 8'd8;

	// shared down/up counter: skips, word bytes and padding (up to 259)
	localparam int CNT_W = 9;
	localparam int WORD_W = 32;

	// result kinds
	typedef enum logic [2:0] {
		KIND_CALL_ID   = 3'd0,
		KIND_DEST      = 3'd1,
		KIND_PATH      = 3'd2,
		KIND_IFACE     = 3'd3,
		KIND_METHOD    = 3'd4,
		KIND_ARG_CHAR  = 3'd5,
		KIND_DONE      = 3'd6,
		KIND_TRUNCATED = 3'd7
	} kind_t;

	// field tags; string tags share their code with the result kind
	typedef enum logic [2:0] {
		TAG_NONE   = 3'd0,
		TAG_DEST   = 3'd1,
		TAG_PATH   = 3'd2,
		TAG_IFACE  = 3'd3,
		TAG_METHOD = 3'd4,
		TAG_DECL   = 3'd5
	} tag_t;

	// parser phases, one-hot
	typedef enum logic [13:0] {
		PH_LEAD    = 14'b00000000000001,
		PH_SKIP3   = 14'b00000000000010,
		PH_BODYLEN = 14'b00000000000100,
		PH_CALLID  = 14'b00000000001000,
		PH_ARRLEN  = 14'b00000000010000,
		PH_FTYPE   = 14'b00000000100000,
		PH_FSKIP3  = 14'b00000001000000,
		PH_FLEN    = 14'b00000010000000,
		PH_FSTR    = 14'b00000100000000,
		PH_FPAD    = 14'b00001000000000,
		PH_DECLN   = 14'b00010000000000,
		PH_ALEN    = 14'b00100000000000,
		PH_ASTR    = 14'b01000000000000,
		PH_DONE    = 14'b10000000000000
	} phase_t;

	// one result beat
	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] value;
		logic [7:0]        arg_index;
		logic [7:0]        arg_count;
		logic              last;
	} beat_t;

endpackage

`default_nettype wire

/* rtl/dbcp_core.sv */
// byte-level parser state machine of the call header parser
// depends on dbcp_pkg and dbus_call_header_parser_assert.svh
`default_nettype none

module dbcp_core #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          link_closed,
	output logic               res_vld,
	output dbcp_pkg::beat_t    res
);

	`include "dbus_call_header_parser_assert.svh"

	dbcp_pkg::phase_t                 phase_q, phase_d;
	logic [dbcp_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic [dbcp_pkg::WORD_W-1:0]      word_q, word_d, word_in;
	logic                             has_body_q, has_body_d;
	logic [2:0]                       fields_left_q, fields_left_d, fin_left;
	dbcp_pkg::tag_t                   tag_q, tag_d;
	logic [LENGTH_BITS-1:0]           slen_q, slen_d, len_in;
	logic [7:0]                       pcount_q, pcount_d;
	logic [7:0]                       arg_q, arg_d, arg_next;
	logic                             word_full, restart, finish, str_last;
	logic [2:0]                       decl_pad;

	// little-endian word assembly: new byte enters at the top
	assign word_in   = {rx_byte, word_q[dbcp_pkg::WORD_W-1:8]};
	assign word_full = (cnt_q[1:0] == 2'd3);
	assign len_in    = word_in[LENGTH_BITS-1:0];
	assign fin_left  = fields_left_q - 3'd1;
	assign str_last  = (slen_q == '0);
	assign arg_next  = arg_q + 8'd1;
	// padding so that count byte + 6 reaches a multiple of 8
	assign decl_pad  = 3'd0 - (rx_byte[2:0] + 3'd6);

	// next state and result for one accepted beat
	always_comb begin
		phase_d       = phase_q;
		cnt_d         = cnt_q;
		word_d        = word_q;
		has_body_d    = has_body_q;
		fields_left_d = fields_left_q;
		tag_d         = tag_q;
		slen_d        = slen_q;
		pcount_d      = pcount_q;
		arg_d         = arg_q;
		restart       = 1'b0;
		finish        = 1'b0;
		res_vld       = 1'b0;
		res           = '0;

		if (link_closed) begin
			// link close: done if the message was complete, else truncated
			if (phase_q != dbcp_pkg::PH_LEAD) begin
				phase_d = dbcp_pkg::PH_LEAD;
				res_vld = 1'b1;
				if (phase_q == dbcp_pkg::PH_DONE) begin
					res.kind      = dbcp_pkg::KIND_DONE;
					res.arg_count = pcount_q;
				end else begin
					res.kind = dbcp_pkg::KIND_TRUNCATED;
				end
			end
		end else begin
			case (phase_q)
				dbcp_pkg::PH_LEAD: begin
					restart = 1'b1;
				end
				dbcp_pkg::PH_DONE: begin
					res_vld       = 1'b1;
					res.kind      = dbcp_pkg::KIND_DONE;
					res.arg_count = pcount_q;
					restart       = 1'b1;
				end
				dbcp_pkg::PH_SKIP3: begin
					cnt_d = cnt_q - dbcp_pkg::CNT_W'(1);
					if (cnt_q == dbcp_pkg::CNT_W'(1)) begin
						phase_d = dbcp_pkg::PH_BODYLEN;
						cnt_d   = '0;
						word_d  = '0;
					end
				end
				dbcp_pkg::PH_BODYLEN: begin
					word_d = word_in;
					cnt_d  = cnt_q + dbcp_pkg::CNT_W'(1);
					if (word_full) begin
						has_body_d = (len_in != '0);
						phase_d    = dbcp_pkg::PH_CALLID;
						cnt_d      = '0;
						word_d     = '0;
					end
				end
				dbcp_pkg::PH_CALLID: begin
					word_d = word_in;
					cnt_d  = cnt_q + dbcp_pkg::CNT_W'(1);
					if (word_full) begin
						res_vld   = 1'b1;
						res.kind  = dbcp_pkg::KIND_CALL_ID;
						res.value = word_in;
						phase_d   = dbcp_pkg::PH_ARRLEN;
						cnt_d     = dbcp_pkg::CNT_W'(4);
					end
				end
				dbcp_pkg::PH_ARRLEN: begin
					cnt_d = cnt_q - dbcp_pkg::CNT_W'(1);
					if (cnt_q == dbcp_pkg::CNT_W'(1)) begin
						fields_left_d = has_body_q ? 3'd5 : 3'd4;
						phase_d       = dbcp_pkg::PH_FTYPE;
					end
				end
				dbcp_pkg::PH_FTYPE: begin
					case (rx_byte)
						dbcp_pkg::FTYPE_DEST:   tag_d = dbcp_pkg::TAG_DEST;
						dbcp_pkg::FTYPE_PATH:   tag_d = dbcp_pkg::TAG_PATH;
						dbcp_pkg::FTYPE_IFACE:  tag_d = dbcp_pkg::TAG_IFACE;
						dbcp_pkg::FTYPE_METHOD: tag_d = dbcp_pkg::TAG_METHOD;
						dbcp_pkg::FTYPE_SIG:    tag_d = dbcp_pkg::TAG_DECL;
						default:                tag_d = dbcp_pkg::TAG_NONE;
					endcase
					// unknown type byte is a whole field by itself
					if (tag_d == dbcp_pkg::TAG_NONE) begin
						finish = 1'b1;
					end else begin
						phase_d = dbcp_pkg::PH_FSKIP3;
						cnt_d   = dbcp_pkg::CNT_W'(3);
					end
				end
				dbcp_pkg::PH_FSKIP3: begin
					cnt_d = cnt_q - dbcp_pkg::CNT_W'(1);
					if (cnt_q == dbcp_pkg::CNT_W'(1)) begin
						if (tag_q == dbcp_pkg::TAG_DECL) begin
							phase_d = dbcp_pkg::PH_DECLN;
						end else begin
							phase_d = dbcp_pkg::PH_FLEN;
							cnt_d   = '0;
							word_d  = '0;
						end
					end
				end
				dbcp_pkg::PH_FLEN: begin
					word_d = word_in;
					cnt_d  = cnt_q + dbcp_pkg::CNT_W'(1);
					if (word_full) begin
						slen_d  = len_in;
						// pad of L+1 up to 8 is the inverse of the low three bits of L
						cnt_d   = {{(dbcp_pkg::CNT_W-3){1'b0}}, ~len_in[2:0]};
						phase_d = dbcp_pkg::PH_FSTR;
					end
				end
				dbcp_pkg::PH_FSTR: begin
					res_vld   = 1'b1;
					res.kind  = dbcp_pkg::kind_t'(tag_q);
					res.value = {{(dbcp_pkg::WORD_W-8){1'b0}}, rx_byte};
					res.last  = str_last;
					if (str_last) begin
						if (cnt_q == '0) begin
							finish = 1'b1;
						end else begin
							phase_d = dbcp_pkg::PH_FPAD;
						end
					end else begin
						slen_d = slen_q - LENGTH_BITS'(1);
					end
				end
				dbcp_pkg::PH_FPAD: begin
					cnt_d = cnt_q - dbcp_pkg::CNT_W'(1);
					if (cnt_q == dbcp_pkg::CNT_W'(1)) begin
						finish = 1'b1;
					end
				end
				dbcp_pkg::PH_DECLN: begin
					// skip the signature text, its terminator and padding
					pcount_d = rx_byte;
					cnt_d    = {1'b0, rx_byte} + dbcp_pkg::CNT_W'(1)
						+ {{(dbcp_pkg::CNT_W-3){1'b0}}, decl_pad};
					phase_d  = dbcp_pkg::PH_FPAD;
				end
				dbcp_pkg::PH_ALEN: begin
					word_d = word_in;
					cnt_d  = cnt_q + dbcp_pkg::CNT_W'(1);
					if (word_full) begin
						slen_d  = len_in;
						phase_d = dbcp_pkg::PH_ASTR;
					end
				end
				dbcp_pkg::PH_ASTR: begin
					res_vld       = 1'b1;
					res.kind      = dbcp_pkg::KIND_ARG_CHAR;
					res.value     = {{(dbcp_pkg::WORD_W-8){1'b0}}, rx_byte};
					res.arg_index = arg_q;
					res.last      = str_last;
					if (str_last) begin
						arg_d = arg_next;
						if (arg_next >= pcount_q || arg_next == 8'd0) begin
							phase_d = dbcp_pkg::PH_DONE;
						end else begin
							phase_d = dbcp_pkg::PH_ALEN;
							cnt_d   = '0;
							word_d  = '0;
						end
					end else begin
						slen_d = slen_q - LENGTH_BITS'(1);
					end
				end
				default: begin
					phase_d = dbcp_pkg::PH_LEAD;
				end
			endcase

			// end of one header field
			if (finish) begin
				fields_left_d = fin_left;
				if (fin_left != 3'd0) begin
					phase_d = dbcp_pkg::PH_FTYPE;
				end else if (has_body_q && pcount_q != 8'd0) begin
					arg_d   = '0;
					phase_d = dbcp_pkg::PH_ALEN;
					cnt_d   = '0;
					word_d  = '0;
				end else begin
					phase_d = dbcp_pkg::PH_DONE;
				end
			end

			// lead byte of a new message
			if (restart) begin
				phase_d       = dbcp_pkg::PH_SKIP3;
				cnt_d         = dbcp_pkg::CNT_W'(3);
				word_d        = '0;
				has_body_d    = 1'b0;
				fields_left_d = '0;
				tag_d         = dbcp_pkg::TAG_NONE;
				slen_d        = '0;
				pcount_d      = '0;
				arg_d         = '0;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= dbcp_pkg::PH_LEAD;
			cnt_q         <= '0;
			word_q        <= '0;
			has_body_q    <= 1'b0;
			fields_left_q <= '0;
			tag_q         <= dbcp_pkg::TAG_NONE;
			slen_q        <= '0;
			pcount_q      <= '0;
			arg_q         <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			cnt_q         <= cnt_d;
			word_q        <= word_d;
			has_body_q    <= has_body_d;
			fields_left_q <= fields_left_d;
			tag_q         <= tag_d;
			slen_q        <= slen_d;
			pcount_q      <= pcount_d;
			arg_q         <= arg_d;
		end
	end

	// string terminator flag only on string characters
	`DBCP_ASSERT_IMPL(a_last_only_on_strings, res_vld && res.last,
		res.kind == dbcp_pkg::KIND_DEST || res.kind == dbcp_pkg::KIND_PATH ||
		res.kind == dbcp_pkg::KIND_IFACE || res.kind == dbcp_pkg::KIND_METHOD ||
		res.kind == dbcp_pkg::KIND_ARG_CHAR, "terminator flag on a non-string result")
	// a link close inside a message always reports
	`DBCP_ASSERT_IMPL(a_close_reports,
		accept && link_closed && phase_q != dbcp_pkg::PH_LEAD, res_vld,
		"link close inside a message gave no result")
	// the call id word is followed by the field-array length
	`DBCP_ASSERT_NEXT(a_callid_to_arrlen,
		accept && !link_closed && phase_q == dbcp_pkg::PH_CALLID && word_full,
		phase_q == dbcp_pkg::PH_ARRLEN, "call id not followed by array length")

endmodule

`default_nettype wire

/* rtl/dbus_call_header_parser.sv */
// Method-call header parser, top level.
//
// Input channel: one beat per received byte (rx_byte), or a link close
// (link_closed = 1, rx_byte ignored). A beat is taken at a rising edge with
// in_valid high and in_stall low. Output channel: result beats (out_kind,
// out_value, arg_index, arg_count, string_last), taken when out_valid is high
// and out_stall low.
// Each input beat gives zero or one result. A result is registered at the edge
// that takes its byte, into the output register or, behind a stalled output,
// into the skid entry. One byte is taken every cycle while the skid entry is
// empty: the parser state machine updates at each edge that takes a byte and
// feeds an output register backed by one skid entry.
// When the receiver stalls, the output register holds its beat, the next
// result goes to the skid entry, and in_stall rises while that entry is full;
// it falls in the cycle after the receiver takes a beat.
// Reset (arst_n low) empties both output slots and puts the parser in the
// state that waits for the lead byte of a message.
// depends on dbcp_pkg, dbcp_core and dbus_call_header_parser_assert.svh
`default_nettype none

module dbus_call_header_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            link_closed,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [2:0]                           out_kind,
	output logic [dbcp_pkg::WORD_W-1:0]          out_value,
	output logic [7:0]                           arg_index,
	output logic [7:0]                           arg_count,
	output logic                                 string_last
);

	`include "dbus_call_header_parser_assert.svh"

	logic            accept, res_vld, take_out, new_res;
	logic            out_load_new, out_load_skid, skid_load;
	logic            out_valid_q, skid_valid_q;
	dbcp_pkg::beat_t res, out_q, skid_q;

	// input handshake: stall only while the skid entry is occupied
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;

	dbcp_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.link_closed (link_closed),
		.res_vld     (res_vld),
		.res         (res)
	);

	// output register and skid steering
	assign take_out      = out_valid_q && !out_stall;
	assign new_res       = accept && res_vld;
	assign out_load_skid = take_out && skid_valid_q;
	assign out_load_new  = new_res && (!out_valid_q || take_out);
	assign skid_load     = new_res && out_valid_q && !take_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= out_load_skid || out_load_new || (out_valid_q && !take_out);
			skid_valid_q <= skid_load || (skid_valid_q && !take_out);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_load_skid) begin
			out_q <= skid_q;
		end else if (out_load_new) begin
			out_q <= res;
		end
		if (skid_load) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_q.kind;
	assign out_value   = out_q.value;
	assign arg_index   = out_q.arg_index;
	assign arg_count   = out_q.arg_count;
	assign string_last = out_q.last;

	// skid entry is only used behind a full output register
	`DBCP_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid entry full with output register empty")
	// a result arriving behind a stalled output lands in the skid entry
	`DBCP_ASSERT_NEXT(a_result_to_skid, new_res && out_valid_q && out_stall,
		skid_valid_q, "result behind a stalled output was dropped")
	// skid entry drains as soon as the receiver takes a beat
	`DBCP_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall, !skid_valid_q,
		"skid entry did not drain")

endmodule

`default_nettype wire
